>>> rtl/core/tdeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdeq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned POS_W         = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned STATUS_W      = 2;
  // stored word: {tag, value}
  localparam int unsigned WORD_W        = VAL_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  function automatic logic is_nan(input logic [VAL_W-1:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // IEEE equality: signed zeros match, NaN never does
  function automatic logic float_eq(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] both;
    both = a | b;
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    if (both[30:0] == 31'd0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tdeq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tdeq_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tagged_double_ended_queue.sv
// Channel   Ports                                              Handshake
// -------   ------------------------------------------------   -------------------------------
// request   cmd_i, is_float_i, byte_value_i, float_bits_i,     taken when start && !busy
//           position_i
// result    status_o, out_is_float_o, out_byte_o,              one cycle, marked by done_o
//           out_float_bits_o, fill_count_o
//
// Every access goes through one single-port-read RAM whose read data is registered.
// Push, failed or unknown request: the result comes from S_DISPATCH; pop and read: from S_RD_WAIT.
// Remove: a miss scans every live entry; a hit shifts each later entry one slot toward the front.
// After reset the deque is empty; the RAM needs no clearing pass.
// busy rises the cycle after a request and drops in the cycle the result shows, so a new
// request may be taken alongside the strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module tagged_double_ended_queue #(
  parameter int unsigned DEPTH = tdeq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [tdeq_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic                           is_float_i,
  input  wire logic [tdeq_pkg::BYTE_W-1:0]    byte_value_i,
  input  wire logic [tdeq_pkg::VAL_W-1:0]     float_bits_i,
  input  wire logic [tdeq_pkg::POS_W-1:0]     position_i,
  output logic                                done_o,
  output logic [tdeq_pkg::STATUS_W-1:0]       status_o,
  output logic                                out_is_float_o,
  output logic [tdeq_pkg::BYTE_W-1:0]         out_byte_o,
  output logic [tdeq_pkg::VAL_W-1:0]          out_float_bits_o,
  output logic [$clog2(DEPTH+1)-1:0]          fill_count_o
);

  import tdeq_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_WAIT,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic               tag_q, tag_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      pend_idx_q, pend_idx_d;
  logic               pend_q, pend_d;
  logic [CW-1:0]      j_q, j_d;
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic               otag_q, otag_d;
  logic [BYTE_W-1:0]  obyte_q, obyte_d;
  logic [VAL_W-1:0]   ofloat_q, ofloat_d;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [AW-1:0]      head_inc, head_dec;
  logic [CMPW-1:0]    pos_ext, cnt_ext;
  logic [CW-1:0]      j_inc;
  logic               full, empty, hit;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] lg);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + {1'b0, lg};
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  tdeq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign pos_ext  = CMPW'(pos_q);
  assign cnt_ext  = CMPW'(count_q);
  assign j_inc    = j_q + CW'(1);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);

  // compare the word read in the previous scan cycle
  assign hit = pend_q && (ram_rdata[VAL_W] == tag_q) &&
               (tag_q ? float_eq(ram_rdata[VAL_W-1:0], val_q)
                      : (ram_rdata[BYTE_W-1:0] == val_q[BYTE_W-1:0]));

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    tag_d      = tag_q;
    val_d      = val_q;
    pos_d      = pos_q;
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pend_idx_d = pend_idx_q;
    pend_d     = pend_q;
    j_d        = j_q;
    done_d     = 1'b0;
    status_d   = status_q;
    otag_d     = otag_q;
    obyte_d    = obyte_q;
    ofloat_d   = ofloat_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = {tag_q, val_q};
    ram_re     = 1'b0;
    ram_raddr  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(cmd_i);
          tag_d   = is_float_i;
          val_d   = is_float_i ? float_bits_i : VAL_W'(byte_value_i);
          pos_d   = position_i;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        // default outcome: finish now with an empty entry
        done_d   = 1'b1;
        status_d = ST_OK;
        otag_d   = 1'b0;
        obyte_d  = '0;
        ofloat_d = '0;
        state_d  = S_IDLE;
        case (cmd_q)
          CMD_PUSH_BACK: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_of(head_q, count_q);
              count_d   = count_q + CW'(1);
            end
          end
          CMD_PUSH_FRONT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = head_dec;
              head_d    = head_dec;
              count_d   = count_q + CW'(1);
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              status_d = ST_MISS;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot_of(head_q, count_q - CW'(1));
              done_d    = 1'b0;
              state_d   = S_RD_WAIT;
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              status_d = ST_MISS;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              done_d    = 1'b0;
              state_d   = S_RD_WAIT;
            end
          end
          CMD_READ: begin
            if (pos_ext >= cnt_ext) begin
              status_d = ST_MISS;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = slot_of(head_q, pos_ext[CW-1:0]);
              done_d    = 1'b0;
              state_d   = S_RD_WAIT;
            end
          end
          CMD_REMOVE: begin
            idx_d   = '0;
            pend_d  = 1'b0;
            done_d  = 1'b0;
            state_d = S_SCAN;
          end
          default: begin
            status_d = ST_MISS;
          end
        endcase
      end

      S_RD_WAIT: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        otag_d   = ram_rdata[VAL_W];
        obyte_d  = ram_rdata[VAL_W] ? '0 : ram_rdata[BYTE_W-1:0];
        ofloat_d = ram_rdata[VAL_W] ? ram_rdata[VAL_W-1:0] : '0;
        state_d  = S_IDLE;
        if (cmd_q == CMD_POP_BACK) begin
          count_d = count_q - CW'(1);
        end else if (cmd_q == CMD_POP_FRONT) begin
          head_d  = head_inc;
          count_d = count_q - CW'(1);
        end
      end

      S_SCAN: begin
        if (hit) begin
          j_d     = pend_idx_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT_RD;
        end else if (idx_q == count_q) begin
          // every live entry compared, none matched
          pend_d   = 1'b0;
          done_d   = 1'b1;
          status_d = ST_MISS;
          state_d  = S_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = slot_of(head_q, idx_q);
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + CW'(1);
        end
      end

      S_SHIFT_RD: begin
        if (j_inc >= count_q) begin
          count_d  = count_q - CW'(1);
          done_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(head_q, j_inc);
          state_d   = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        // move the later entry one slot toward the front
        ram_we    = 1'b1;
        ram_waddr = slot_of(head_q, j_q);
        ram_wdata = ram_rdata;
        j_d       = j_inc;
        state_d   = S_SHIFT_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= CMD_PUSH_BACK;
      tag_q      <= 1'b0;
      val_q      <= '0;
      pos_q      <= '0;
      head_q     <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      pend_idx_q <= '0;
      pend_q     <= 1'b0;
      j_q        <= '0;
      done_q     <= 1'b0;
      status_q   <= ST_OK;
      otag_q     <= 1'b0;
      obyte_q    <= '0;
      ofloat_q   <= '0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      tag_q      <= tag_d;
      val_q      <= val_d;
      pos_q      <= pos_d;
      head_q     <= head_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      pend_idx_q <= pend_idx_d;
      pend_q     <= pend_d;
      j_q        <= j_d;
      done_q     <= done_d;
      status_q   <= status_d;
      otag_q     <= otag_d;
      obyte_q    <= obyte_d;
      ofloat_q   <= ofloat_d;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_is_float_o   = otag_q;
  assign out_byte_o       = obyte_q;
  assign out_float_bits_o = ofloat_q;
  assign fill_count_o     = count_q;

endmodule

`default_nettype wire

>>> rtl/core/tdeq_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module tdeq_chk #(
  parameter int unsigned DEPTH = tdeq_pkg::DEPTH_DEFAULT
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [tdeq_pkg::STATUS_W-1:0] status_o,
  input wire logic                        out_is_float_o,
  input wire logic [tdeq_pkg::BYTE_W-1:0] out_byte_o,
  input wire logic [tdeq_pkg::VAL_W-1:0]  out_float_bits_o,
  input wire logic [$clog2(DEPTH+1)-1:0]  fill_count_o
);

  import tdeq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // one request never yields two results in a row
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_fail_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (!out_is_float_o && out_byte_o == '0 && out_float_bits_o == '0))
    else $error("failed request returned entry data");

  a_tag_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_is_float_o ? (out_byte_o == '0) : (out_float_bits_o == '0)))
    else $error("returned entry fields disagree with tag");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (fill_count_o == CW'(DEPTH)))
    else $error("full status while store not full");

endmodule

bind tagged_double_ended_queue tdeq_chk #(.DEPTH(DEPTH)) u_tdeq_chk (.*);

`default_nettype wire

>>> bench/tagged_double_ended_queue_tb.sv
`timescale 1ns / 1ps

module tagged_double_ended_queue_tb;
  import tdeq_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int unsigned COUNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SETTLE_CYC  = 64;
  localparam int unsigned REPORT_MAX  = 10;

  // command codes the block does not implement
  localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

  localparam logic [VAL_W-1:0] FP_POS_ZERO = 32'h0000_0000;
  localparam logic [VAL_W-1:0] FP_NEG_ZERO = 32'h8000_0000;
  localparam logic [VAL_W-1:0] FP_QNAN     = 32'h7FC0_0000;
  localparam logic [VAL_W-1:0] FP_SNAN     = 32'h7F80_0001;
  localparam logic [VAL_W-1:0] FP_POS_INF  = 32'h7F80_0000;
  localparam logic [VAL_W-1:0] FP_NEG_INF  = 32'hFF80_0000;
  localparam logic [VAL_W-1:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [VAL_W-1:0] FP_ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             tag;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                is_float;
    logic [BYTE_W-1:0]   data_byte;
    logic [VAL_W-1:0]    fbits;
    logic [COUNT_W-1:0]  count;
  } response_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     cmd_i = '0;
  logic                 is_float_i = 1'b0;
  logic [BYTE_W-1:0]    byte_value_i = '0;
  logic [VAL_W-1:0]     float_bits_i = '0;
  logic [POS_W-1:0]     position_i = '0;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 out_is_float_o;
  logic [BYTE_W-1:0]    out_byte_o;
  logic [VAL_W-1:0]     out_float_bits_o;
  logic [COUNT_W-1:0]   fill_count_o;

  entry_t      held_entries[$];
  response_t   pending_responses[$];
  int unsigned mismatches = 0;
  int unsigned responses_seen = 0;
  int unsigned burst_left = 0;

  tagged_double_ended_queue #(.DEPTH(DEPTH)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .is_float_i      (is_float_i),
    .byte_value_i    (byte_value_i),
    .float_bits_i    (float_bits_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_is_float_o  (out_is_float_o),
    .out_byte_o      (out_byte_o),
    .out_float_bits_o(out_float_bits_o),
    .fill_count_o    (fill_count_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit float_is_nan(input logic [VAL_W-1:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic bit floats_match(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    if (float_is_nan(a) || float_is_nan(b)) begin
      return 1'b0;
    end
    // signed zeros compare equal
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  function automatic response_t with_entry(input response_t rsp, input entry_t ent);
    rsp.is_float = ent.tag;
    if (ent.tag) begin
      rsp.fbits = ent.value;
    end else begin
      rsp.data_byte = ent.value[BYTE_W-1:0];
    end
    return rsp;
  endfunction

  // Apply one request to the shadow deque and return the response it must produce.
  function automatic response_t apply_request(input logic [CMD_W-1:0] cmd, input logic tag,
                                              input logic [BYTE_W-1:0] bval,
                                              input logic [VAL_W-1:0] fval,
                                              input logic [POS_W-1:0] pos);
    response_t rsp;
    entry_t    ent;
    bit        found;
    rsp = '0;
    rsp.status = ST_OK;
    found = 1'b0;
    ent.tag = tag;
    ent.value = tag ? fval : {{(VAL_W-BYTE_W){1'b0}}, bval};
    case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (held_entries.size() >= DEPTH) begin
          rsp.status = ST_FULL;
        end else if (cmd == CMD_PUSH_BACK) begin
          held_entries.push_back(ent);
        end else begin
          held_entries.push_front(ent);
        end
      end
      CMD_POP_BACK: begin
        if (held_entries.size() == 0) begin
          rsp.status = ST_MISS;
        end else begin
          rsp = with_entry(rsp, held_entries.pop_back());
        end
      end
      CMD_POP_FRONT: begin
        if (held_entries.size() == 0) begin
          rsp.status = ST_MISS;
        end else begin
          rsp = with_entry(rsp, held_entries.pop_front());
        end
      end
      CMD_READ: begin
        if (pos >= held_entries.size()) begin
          rsp.status = ST_MISS;
        end else begin
          rsp = with_entry(rsp, held_entries[pos]);
        end
      end
      CMD_REMOVE: begin
        rsp.status = ST_MISS;
        for (int i = 0; i < held_entries.size() && !found; i++) begin
          if (held_entries[i].tag == tag &&
              (tag ? floats_match(held_entries[i].value, fval)
                   : held_entries[i].value[BYTE_W-1:0] == bval)) begin
            held_entries.delete(i);
            found = 1'b1;
            rsp.status = ST_OK;
          end
        end
      end
      default: begin
        rsp.status = ST_MISS;
      end
    endcase
    rsp.count = COUNT_W'(held_entries.size());
    return rsp;
  endfunction

  task automatic compare_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("response %0d %s: expected %h, got %h", responses_seen, name, want, got);
      end
    end
  endtask

  // Check each strobed response, then record any request taken at this edge.
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("response %0d: strobe with no request outstanding", responses_seen);
          end
        end else begin
          want = pending_responses.pop_front();
          compare_field("status", VAL_W'(want.status), VAL_W'(status_o));
          compare_field("out_is_float", VAL_W'(want.is_float), VAL_W'(out_is_float_o));
          compare_field("out_byte", VAL_W'(want.data_byte), VAL_W'(out_byte_o));
          compare_field("out_float_bits", want.fbits, out_float_bits_o);
          compare_field("fill_count", VAL_W'(want.count), VAL_W'(fill_count_o));
        end
        responses_seen++;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        pending_responses.push_back(apply_request(cmd_i, is_float_i, byte_value_i,
                                                  float_bits_i, position_i));
      end
    end
  end

  // Leaves start high; the caller either sends again or drops it in pace.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic tag,
                              input logic [BYTE_W-1:0] bval, input logic [VAL_W-1:0] fval,
                              input logic [POS_W-1:0] pos);
    start        <= 1'b1;
    cmd_i        <= cmd;
    is_float_i   <= tag;
    byte_value_i <= bval;
    float_bits_i <= fval;
    position_i   <= pos;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    // narrow range half the time so removals find hits
    return ($urandom_range(0, 1) == 1) ? BYTE_W'($urandom_range(0, 7))
                                       : BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VAL_W-1:0] pick_float();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      case ($urandom_range(0, 7))
        0: return FP_POS_ZERO;
        1: return FP_NEG_ZERO;
        2: return FP_QNAN;
        3: return FP_SNAN;
        4: return FP_POS_INF;
        5: return FP_NEG_INF;
        6: return FP_ONE;
        default: return FP_ALL_ONES;
      endcase
    end else if (roll < 6) begin
      return FP_ONE | $urandom_range(0, 3);
    end
    return $urandom();
  endfunction

  task automatic random_request(input int unsigned profile);
    logic [CMD_W-1:0]  cmd;
    logic              tag;
    logic [BYTE_W-1:0] bval;
    logic [VAL_W-1:0]  fval;
    logic [POS_W-1:0]  pos;
    int unsigned       roll;
    int unsigned       push_pct;
    int unsigned       pop_pct;
    int unsigned       read_pct;
    int unsigned       live;
    entry_t            pick;
    case (profile)
      0: begin push_pct = 60; pop_pct = 15; read_pct = 10; end
      1: begin push_pct = 20; pop_pct = 45; read_pct = 12; end
      default: begin push_pct = 38; pop_pct = 30; read_pct = 14; end
    endcase
    roll = $urandom_range(0, 99);
    tag  = 1'($urandom_range(0, 1));
    bval = pick_byte();
    fval = pick_float();
    pos  = POS_W'($urandom_range(0, 15));
    live = held_entries.size();
    if (roll < push_pct) begin
      cmd = ($urandom_range(0, 1) == 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else if (roll < push_pct + pop_pct) begin
      cmd = ($urandom_range(0, 1) == 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    end else if (roll < push_pct + pop_pct + read_pct) begin
      cmd = CMD_READ;
      // aim near the live range, one past the end included
      if ($urandom_range(0, 3) != 0) begin
        pos = POS_W'($urandom_range(0, (live > 15) ? 15 : live));
      end
    end else if (roll < 97) begin
      cmd = CMD_REMOVE;
      if (live != 0 && $urandom_range(0, 4) != 0) begin
        pick = held_entries[$urandom_range(0, live - 1)];
        tag  = pick.tag;
        if (pick.tag) begin
          fval = pick.value;
          if (fval[30:0] == 31'd0 && $urandom_range(0, 1) == 1) begin
            fval[31] = ~fval[31];
          end
        end else begin
          bval = pick.value[BYTE_W-1:0];
        end
      end
    end else begin
      cmd = ($urandom_range(0, 1) == 1) ? CMD_RESERVED_HI : CMD_RESERVED_LO;
    end
    send_request(cmd, tag, bval, fval, pos);
  endtask

  task automatic test_empty_and_unknown();
    send_request(CMD_POP_BACK, 1'b0, 8'h00, FP_POS_ZERO, 4'd0);
    send_request(CMD_POP_FRONT, 1'b1, 8'hFF, FP_ALL_ONES, 4'd15);
    send_request(CMD_READ, 1'b0, 8'h00, FP_POS_ZERO, 4'd15);
    send_request(CMD_REMOVE, 1'b1, 8'h00, FP_POS_ZERO, 4'd0);
    send_request(CMD_RESERVED_LO, 1'b0, 8'hFF, FP_ALL_ONES, 4'd0);
    send_request(CMD_RESERVED_HI, 1'b1, 8'h00, FP_POS_ZERO, 4'd15);
  endtask

  task automatic test_signed_zero_and_nan();
    send_request(CMD_PUSH_BACK, 1'b1, 8'h00, FP_NEG_ZERO, 4'd0);
    send_request(CMD_PUSH_FRONT, 1'b0, 8'hFF, FP_POS_ZERO, 4'd0);
    send_request(CMD_PUSH_BACK, 1'b1, 8'h00, FP_QNAN, 4'd0);
    send_request(CMD_PUSH_FRONT, 1'b1, 8'h00, FP_POS_INF, 4'd0);
    send_request(CMD_REMOVE, 1'b1, 8'h00, FP_POS_ZERO, 4'd0);
    send_request(CMD_REMOVE, 1'b1, 8'h00, FP_QNAN, 4'd0);
    send_request(CMD_REMOVE, 1'b0, 8'h00, FP_POS_ZERO, 4'd0);
    send_request(CMD_READ, 1'b0, 8'h00, FP_POS_ZERO, 4'd1);
    send_request(CMD_READ, 1'b0, 8'h00, FP_POS_ZERO, 4'd3);
    send_request(CMD_POP_FRONT, 1'b0, 8'h00, FP_POS_ZERO, 4'd0);
    send_request(CMD_POP_BACK, 1'b0, 8'h00, FP_POS_ZERO, 4'd0);
  endtask

  task automatic test_fill_and_overflow();
    logic [VAL_W-1:0] fval;
    for (int i = 0; i < DEPTH; i++) begin
      fval = (i == DEPTH - 1) ? FP_ALL_ONES : (FP_ONE + i);
      send_request(i[1] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, i[0], 8'(i * 17), fval, 4'd0);
    end
    send_request(CMD_PUSH_BACK, 1'b0, 8'h00, FP_POS_ZERO, 4'd0);
    send_request(CMD_PUSH_FRONT, 1'b1, 8'h00, FP_NEG_ZERO, 4'd0);
    send_request(CMD_READ, 1'b0, 8'h00, FP_POS_ZERO, 4'd15);
    send_request(CMD_REMOVE, 1'b0, 8'h44, FP_POS_ZERO, 4'd0);
    send_request(CMD_REMOVE, 1'b1, 8'h00, FP_ALL_ONES, 4'd0);
  endtask

  task automatic test_random_traffic(input int unsigned total);
    int unsigned profile;
    profile = 0;
    for (int unsigned n = 0; n < total; n++) begin
      // swing between filling, draining and mixed traffic
      if (n % 100 == 0) begin
        profile = $urandom_range(0, 2);
      end
      random_request(profile);
      pace();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_unknown();
    test_signed_zero_and_nan();
    test_fill_and_overflow();
    test_random_traffic(1600);
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("tagged_double_ended_queue_tb: PASS");
    end else begin
      $display("tagged_double_ended_queue_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tagged_double_ended_queue_tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tdeq_pkg.sv
rtl/core/tdeq_ram.sv
rtl/core/tagged_double_ended_queue.sv
rtl/core/tdeq_chk.sv
bench/tagged_double_ended_queue_tb.sv
